[rtl/wfm_pkg.sv]
// Shared types and constants for the windowed FFT magnitude core.
// Holds the item structs, the front-to-back command and the CORDIC angle table.
// No dependencies.
package wfm_pkg;

    localparam int CMD_AW       = 10;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CORDIC_STEPS = 30;
    localparam int ZW           = 34;
    localparam int SQ_W         = 48;

    localparam logic signed [ZW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0]          HALF_PI_Q30     = 31'd1686629713;
    localparam logic [16:0]          Q15_ONE         = 17'd32768;
    localparam logic [22:0]          MAG_MAX         = 23'h7FFFFF;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
    } t_in;

    typedef struct packed {
        logic [5:0]         bin_index;
        logic signed [23:0] bin_real;
        logic signed [23:0] bin_imag;
        logic [22:0]        bin_magnitude;
        logic               last_bin;
    } t_out;

    typedef struct packed {
        logic              store;
        logic              run;
        logic [CMD_AW-1:0] addr;
        logic [CMD_AW:0]   count;
        logic [15:0]       data;
    } t_cmd;

    typedef struct packed {
        logic               done;
        logic signed [16:0] cos_v;
        logic signed [16:0] sin_v;
    } t_trig;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] k);
        logic signed [ZW-1:0] a;
        case (k)
            5'd0:    a = 34'sd843314857;
            5'd1:    a = 34'sd497837829;
            5'd2:    a = 34'sd263043837;
            5'd3:    a = 34'sd133525159;
            5'd4:    a = 34'sd67021687;
            5'd5:    a = 34'sd33543516;
            5'd6:    a = 34'sd16775851;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194283;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048576;
            5'd11:   a = 34'sd524288;
            5'd12:   a = 34'sd262144;
            5'd13:   a = 34'sd131072;
            5'd14:   a = 34'sd65536;
            5'd15:   a = 34'sd32768;
            5'd16:   a = 34'sd16384;
            5'd17:   a = 34'sd8192;
            5'd18:   a = 34'sd4096;
            5'd19:   a = 34'sd2048;
            5'd20:   a = 34'sd1024;
            5'd21:   a = 34'sd512;
            5'd22:   a = 34'sd256;
            5'd23:   a = 34'sd128;
            5'd24:   a = 34'sd64;
            5'd25:   a = 34'sd32;
            5'd26:   a = 34'sd16;
            5'd27:   a = 34'sd8;
            5'd28:   a = 34'sd4;
            5'd29:   a = 34'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[rtl/wfm_front.sv]
// Input front end: counts samples, drops those past the buffer, flags the run.
// Depends on wfm_pkg.
module wfm_front #(
    parameter int FFT_POINTS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  wfm_pkg::t_in  i_item,
    output logic          o_push,
    output wfm_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    localparam int AW = $clog2(FFT_POINTS);
    localparam int CW = AW + 1;

    logic [CW-1:0] r_held;
    logic [CW-1:0] n_held;
    logic          w_acc;
    logic          w_store;
    logic [CW-1:0] w_count;

    assign o_stall = i_full;
    assign w_acc   = i_valid && !i_full;
    assign w_store = r_held < CW'(FFT_POINTS);
    assign w_count = w_store ? r_held + CW'(1) : r_held;
    assign o_push  = w_acc && (w_store || i_item.last_sample);

    always_comb begin
        o_cmd.store = w_store;
        o_cmd.run   = i_item.last_sample;
        o_cmd.addr  = wfm_pkg::CMD_AW'(r_held[AW-1:0]);
        o_cmd.count = (wfm_pkg::CMD_AW + 1)'(w_count);
        o_cmd.data  = i_item.sample;
    end

    always_comb begin
        n_held = r_held;
        if (w_acc) begin
            n_held = i_item.last_sample ? '0 : w_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

endmodule

[rtl/wfm_queue.sv]
// Short command queue between the front end and the FFT engine.
// Depends on wfm_pkg.
module wfm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wfm_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output wfm_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    localparam int D  = wfm_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(D);

    wfm_pkg::t_cmd r_slot [D];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = r_cnt == (PW + 1)'(D);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_slot[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + PW'(1);
            if (w_pop)  r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + (PW + 1)'(w_push) - (PW + 1)'(w_pop);
        end
    end

endmodule

[rtl/wfm_cordic.sv]
// Iterative CORDIC for cosine and sine of a phase in turns, Q15 results.
// Depends on wfm_pkg.
module wfm_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [31:0]    i_phase,
    output wfm_pkg::t_trig o_res
);
    localparam int ZW = wfm_pkg::ZW;

    typedef enum logic [1:0] {C_IDLE, C_ZMUL, C_ITER, C_FIN} t_cstate;

    t_cstate              r_state;
    logic [1:0]           r_quad;
    logic [29:0]          r_frac;
    logic signed [ZW-1:0] r_x;
    logic signed [ZW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [4:0]           r_k;
    logic                 r_done;
    logic signed [16:0]   r_cos;
    logic signed [16:0]   r_sin;
    logic [60:0]          w_zprod;
    logic signed [ZW-1:0] w_dx;
    logic signed [ZW-1:0] w_dy;
    logic signed [ZW-1:0] w_xr;
    logic signed [ZW-1:0] w_yr;
    logic signed [16:0]   w_xc;
    logic signed [16:0]   w_yc;

    function automatic logic signed [16:0] clamp_unit(input logic signed [18:0] v);
        logic signed [16:0] c;
        if (v > 19'sd32768)       c = 17'sd32768;
        else if (v < -19'sd32768) c = -17'sd32768;
        else                      c = v[16:0];
        return c;
    endfunction

    assign w_zprod = 61'(r_frac) * 61'(wfm_pkg::HALF_PI_Q30) + 61'(1 << 29);
    assign w_dx    = r_y >>> r_k;
    assign w_dy    = r_x >>> r_k;
    assign w_xr    = r_x + ZW'(16384);
    assign w_yr    = r_y + ZW'(16384);
    assign w_xc    = clamp_unit($signed(w_xr[ZW-1:15]));
    assign w_yc    = clamp_unit($signed(w_yr[ZW-1:15]));

    assign o_res.done  = r_done;
    assign o_res.cos_v = r_cos;
    assign o_res.sin_v = r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == C_FIN);
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_quad  <= i_phase[31:30];
                        r_frac  <= i_phase[29:0];
                        r_state <= C_ZMUL;
                    end
                end
                C_ZMUL: begin
                    r_z     <= ZW'(w_zprod[60:30]);
                    r_x     <= wfm_pkg::CORDIC_GAIN_Q30;
                    r_y     <= '0;
                    r_k     <= '0;
                    r_state <= C_ITER;
                end
                C_ITER: begin
                    if (!r_z[ZW-1]) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - wfm_pkg::atan_q30(r_k);
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + wfm_pkg::atan_q30(r_k);
                    end
                    if (r_k == 5'(wfm_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= C_FIN;
                    end else begin
                        r_k <= r_k + 5'd1;
                    end
                end
                C_FIN: begin
                    case (r_quad)
                        2'd0:    begin r_cos <= w_xc;  r_sin <= w_yc;  end
                        2'd1:    begin r_cos <= -w_yc; r_sin <= w_xc;  end
                        2'd2:    begin r_cos <= -w_xc; r_sin <= -w_yc; end
                        default: begin r_cos <= w_yc;  r_sin <= -w_xc; end
                    endcase
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

[rtl/wfm_engine.sv]
// FFT engine: capture buffer, Hann window, radix-2 butterflies, magnitude output.
// Depends on wfm_pkg and wfm_cordic.
module wfm_engine #(
    parameter int FFT_POINTS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  wfm_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    output wfm_pkg::t_out o_out_item,
    input  logic          i_out_stall
);
    localparam int AW  = $clog2(FFT_POINTS);
    localparam int CW  = AW + 1;
    localparam int SW  = $clog2(AW + 1);
    localparam int NW  = AW + 32;
    localparam int DCW = $clog2(NW + 1);
    localparam int QW  = wfm_pkg::SQ_W;

    typedef struct packed {
        logic signed [23:0] re;
        logic signed [23:0] im;
    } t_cplx;

    typedef enum logic [4:0] {
        S_IDLE, S_WIN_START, S_DIV, S_WIN_COS, S_WIN_RD, S_WIN_MUL, S_WIN_WR,
        S_TW_START, S_TW_WAIT, S_BF_RD, S_BF_MUL, S_BF_ADD, S_BF_WP, S_BF_WQ,
        S_OUT_RD, S_OUT_SQ, S_OUT_SUM, S_SQRT, S_OUT_PUT
    } t_state;

    logic [15:0]   raw_mem  [FFT_POINTS];
    t_cplx         work_mem [FFT_POINTS];
    logic [15:0]   r_raw_rd;
    t_cplx         r_rd0;
    t_cplx         r_rd1;

    t_state               r_state;
    logic [CW-1:0]        r_m;
    logic [CW-1:0]        r_i;
    logic [SW-1:0]        r_s;
    logic [AW-1:0]        r_j;
    logic [AW-1:0]        r_base;
    logic [NW-1:0]        r_num;
    logic [AW:0]          r_rem_d;
    logic [31:0]          r_quo;
    logic [DCW-1:0]       r_dcnt;
    logic                 r_cs_start;
    logic [31:0]          r_cs_phase;
    logic [16:0]          r_weight;
    logic signed [33:0]   r_wprod;
    logic signed [16:0]   r_wc;
    logic signed [16:0]   r_ws;
    logic signed [40:0]   r_p0;
    logic signed [40:0]   r_p1;
    logic signed [40:0]   r_p2;
    logic signed [40:0]   r_p3;
    t_cplx                r_a;
    t_cplx                r_pres;
    t_cplx                r_qres;
    t_cplx                r_bin;
    logic [QW-1:0]        r_sq0;
    logic [QW-1:0]        r_sq1;
    logic [QW-1:0]        r_rem;
    logic [QW-1:0]        r_root;
    logic [QW-1:0]        r_bit;
    logic                 r_ovalid;
    wfm_pkg::t_out        r_oitem;

    wfm_pkg::t_trig       w_cs;
    logic                 w_we;
    logic [AW-1:0]        w_wa;
    t_cplx                w_wd;
    logic [AW-1:0]        w_p;
    logic [AW-1:0]        w_q;
    logic [AW:0]          w_half;
    logic [AW:0]          w_span;
    logic [AW:0]          w_nbase;
    logic [AW-1:0]        w_den;
    logic [AW:0]          w_rsh;
    logic                 w_qbit;
    logic [AW:0]          w_rnext;
    logic [33:0]          w_xr;
    logic signed [23:0]   w_x;
    logic [41:0]          w_tr_sum;
    logic [41:0]          w_ti_sum;
    logic signed [26:0]   w_tr;
    logic signed [26:0]   w_ti;
    logic [23:0]          w_ure;
    logic [23:0]          w_uim;
    logic [QW-1:0]        w_trial;
    logic [QW-1:0]        w_mag_r;
    logic [22:0]          w_mag;
    logic                 w_out_free;
    logic                 w_last_i;

    function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
        logic [AW-1:0] r;
        for (int b = 0; b < AW; b++) begin
            r[b] = v[AW-1-b];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        logic signed [23:0] r;
        if (v > 28'sd8388607)       r = 24'sh7FFFFF;
        else if (v < -28'sd8388608) r = 24'sh800000;
        else                        r = v[23:0];
        return r;
    endfunction

    wfm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cs_start),
        .i_phase (r_cs_phase),
        .o_res   (w_cs)
    );

    assign w_half  = (AW + 1)'(1) << (r_s - SW'(1));
    assign w_span  = (AW + 1)'(1) << r_s;
    assign w_p     = r_base + r_j;
    assign w_q     = w_p + w_half[AW-1:0];
    assign w_nbase = (AW + 1)'(r_base) + w_span;
    assign w_den   = AW'(r_m - CW'(1));
    assign w_last_i = r_i == CW'(FFT_POINTS - 1);

    assign w_rsh   = {r_rem_d[AW-1:0], r_num[NW-1]};
    assign w_qbit  = w_rsh >= (AW + 1)'(w_den);
    assign w_rnext = w_qbit ? w_rsh - (AW + 1)'(w_den) : w_rsh;

    assign w_xr = r_wprod + 34'sd16384;
    assign w_x  = 24'($signed(w_xr[33:15]));

    assign w_tr_sum = 42'(r_p0) + 42'(r_p1) + 42'd16384;
    assign w_ti_sum = 42'(r_p2) - 42'(r_p3) + 42'd16384;
    assign w_tr     = $signed(w_tr_sum[41:15]);
    assign w_ti     = $signed(w_ti_sum[41:15]);

    assign w_ure = r_rd0.re[23] ? 24'(-r_rd0.re) : r_rd0.re;
    assign w_uim = r_rd0.im[23] ? 24'(-r_rd0.im) : r_rd0.im;

    assign w_trial    = r_root + r_bit;
    assign w_mag_r    = (r_rem > r_root) ? r_root + QW'(1) : r_root;
    assign w_mag      = (|w_mag_r[QW-1:23]) ? wfm_pkg::MAG_MAX : w_mag_r[22:0];
    assign w_out_free = !r_ovalid || !i_out_stall;

    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    always_comb begin
        w_we = 1'b0;
        w_wa = w_p;
        w_wd = r_pres;
        case (r_state)
            S_WIN_START: begin
                w_we = r_i >= r_m;
                w_wa = bitrev(r_i[AW-1:0]);
                w_wd = '0;
            end
            S_WIN_WR: begin
                w_we = 1'b1;
                w_wa = bitrev(r_i[AW-1:0]);
                w_wd = '{re: w_x, im: 24'sd0};
            end
            S_BF_WP: begin
                w_we = 1'b1;
            end
            S_BF_WQ: begin
                w_we = 1'b1;
                w_wa = w_q;
                w_wd = r_qres;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.store) begin
            raw_mem[i_cmd.addr[AW-1:0]] <= i_cmd.data;
        end
        r_raw_rd <= raw_mem[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            work_mem[w_wa] <= w_wd;
        end
        r_rd0 <= work_mem[w_p];
        r_rd1 <= work_mem[w_q];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cs_start <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_cs_start <= (r_state == S_TW_START) ||
                          (r_state == S_DIV && r_dcnt == DCW'(NW - 1));
            if (r_ovalid && !i_out_stall && r_state != S_OUT_PUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && i_cmd.run) begin
                        r_m     <= i_cmd.count[CW-1:0];
                        r_i     <= '0;
                        r_state <= S_WIN_START;
                    end
                end
                S_WIN_START: begin
                    if (r_i >= r_m) begin
                        if (w_last_i) begin
                            r_s     <= SW'(1);
                            r_j     <= '0;
                            r_base  <= '0;
                            r_state <= S_TW_START;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end else if (r_m == CW'(1)) begin
                        r_weight <= wfm_pkg::Q15_ONE;
                        r_state  <= S_WIN_RD;
                    end else begin
                        r_num   <= {r_i[AW-1:0], 32'd0} + NW'(w_den >> 1);
                        r_rem_d <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_num   <= r_num << 1;
                    r_rem_d <= w_rnext;
                    r_quo   <= {r_quo[30:0], w_qbit};
                    r_dcnt  <= r_dcnt + DCW'(1);
                    if (r_dcnt == DCW'(NW - 1)) begin
                        r_cs_phase <= {r_quo[30:0], w_qbit};
                        r_state    <= S_WIN_COS;
                    end
                end
                S_WIN_COS: begin
                    if (w_cs.done) begin
                        r_weight <= 17'((19'sd32769 - 19'(w_cs.cos_v)) >>> 1);
                        r_state  <= S_WIN_RD;
                    end
                end
                S_WIN_RD: begin
                    r_state <= S_WIN_MUL;
                end
                S_WIN_MUL: begin
                    r_wprod <= $signed(r_raw_rd) * $signed({1'b0, r_weight});
                    r_state <= S_WIN_WR;
                end
                S_WIN_WR: begin
                    if (w_last_i) begin
                        r_s     <= SW'(1);
                        r_j     <= '0;
                        r_base  <= '0;
                        r_state <= S_TW_START;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_WIN_START;
                    end
                end
                S_TW_START: begin
                    r_cs_phase <= {{(32 - AW){1'b0}}, r_j} << (6'd32 - 6'(r_s));
                    r_state    <= S_TW_WAIT;
                end
                S_TW_WAIT: begin
                    if (w_cs.done) begin
                        r_wc    <= w_cs.cos_v;
                        r_ws    <= w_cs.sin_v;
                        r_state <= S_BF_RD;
                    end
                end
                S_BF_RD: begin
                    r_state <= S_BF_MUL;
                end
                S_BF_MUL: begin
                    r_p0    <= r_wc * r_rd1.re;
                    r_p1    <= r_ws * r_rd1.im;
                    r_p2    <= r_wc * r_rd1.im;
                    r_p3    <= r_ws * r_rd1.re;
                    r_a     <= r_rd0;
                    r_state <= S_BF_ADD;
                end
                S_BF_ADD: begin
                    r_pres.re <= sat24(28'(r_a.re) + 28'(w_tr));
                    r_pres.im <= sat24(28'(r_a.im) + 28'(w_ti));
                    r_qres.re <= sat24(28'(r_a.re) - 28'(w_tr));
                    r_qres.im <= sat24(28'(r_a.im) - 28'(w_ti));
                    r_state   <= S_BF_WP;
                end
                S_BF_WP: begin
                    r_state <= S_BF_WQ;
                end
                S_BF_WQ: begin
                    if (!w_nbase[AW]) begin
                        r_base  <= w_nbase[AW-1:0];
                        r_state <= S_BF_RD;
                    end else begin
                        r_base <= '0;
                        if ((AW + 1)'(r_j) + (AW + 1)'(1) == w_half) begin
                            r_j <= '0;
                            if (r_s == SW'(AW)) begin
                                r_state <= S_OUT_RD;
                            end else begin
                                r_s     <= r_s + SW'(1);
                                r_state <= S_TW_START;
                            end
                        end else begin
                            r_j     <= r_j + AW'(1);
                            r_state <= S_TW_START;
                        end
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_SQ;
                end
                S_OUT_SQ: begin
                    r_bin   <= r_rd0;
                    r_sq0   <= QW'(w_ure) * QW'(w_ure);
                    r_sq1   <= QW'(w_uim) * QW'(w_uim);
                    r_state <= S_OUT_SUM;
                end
                S_OUT_SUM: begin
                    r_rem   <= r_sq0 + r_sq1;
                    r_root  <= '0;
                    r_bit   <= QW'(1) << (QW - 2);
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_state <= S_OUT_PUT;
                    end else begin
                        if (r_rem >= w_trial) begin
                            r_rem  <= r_rem - w_trial;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_OUT_PUT: begin
                    if (w_out_free) begin
                        r_ovalid                <= 1'b1;
                        r_oitem.bin_index       <= 6'(r_j);
                        r_oitem.bin_real        <= r_bin.re;
                        r_oitem.bin_imag        <= r_bin.im;
                        r_oitem.bin_magnitude   <= w_mag;
                        r_oitem.last_bin        <= r_j == AW'(FFT_POINTS / 2 - 1);
                        if (r_j == AW'(FFT_POINTS / 2 - 1)) begin
                            r_j     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + AW'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_trig_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cs.done |-> (r_state == S_WIN_COS || r_state == S_TW_WAIT))
        else $error("trig result arrived while engine was not waiting");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_PUT && w_out_free && r_j == AW'(FFT_POINTS / 2 - 1))
        |=> (r_state == S_IDLE && r_ovalid && r_oitem.last_bin))
        else $error("final bin did not close the run");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> r_ovalid)
        else $error("stalled bin was dropped");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.run) |=> (r_state == S_WIN_START && r_i == '0))
        else $error("run command did not start the window pass");

endmodule

[rtl/windowed_fft_magnitude_core.sv]
// Top level of the windowed FFT magnitude core.
// Depends on wfm_pkg, wfm_front, wfm_queue and wfm_engine.
//
// Samples are taken one per cycle while o_in_stall is low, into a capture
// buffer of FFT_POINTS entries (a power of two, 8 to 128); samples beyond the
// buffer are dropped, and the item flagged last_sample starts a run on the M
// samples held. A run applies a Hann window, zero-pads, performs a radix-2 DIT
// FFT and delivers bins 0..FFT_POINTS/2-1 in order. All trig values come from
// one shared iterative CORDIC: with M above one, the window takes a bit-serial
// phase divide plus a CORDIC per held sample; the butterflies use the dual-read
// work memory and one CORDIC per twiddle; each output bin goes through an
// iterative square root. While a run is in progress up to four items queue
// ahead; then input stalls.
module windowed_fft_magnitude_core #(
    parameter int FFT_POINTS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  wfm_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output wfm_pkg::t_out o_out_item
);
    logic          w_push;
    wfm_pkg::t_cmd w_push_cmd;
    logic          w_full;
    logic          w_q_valid;
    wfm_pkg::t_cmd w_head;
    logic          w_pop;

    wfm_front #(.FFT_POINTS(FFT_POINTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd),
        .i_full  (w_full)
    );

    wfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_head),
        .i_pop   (w_pop)
    );

    wfm_engine #(.FFT_POINTS(FFT_POINTS)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_cmd       (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

[bench/tb_windowed_fft_magnitude_core.sv]
// Testbench for windowed_fft_magnitude_core: directed table of waveforms, then random frames.
// Spectra are predicted by a fixed-point Hann/CORDIC/FFT model kept in this file.
// Depends on wfm_pkg and the core RTL.
module tb_windowed_fft_magnitude_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_PTS      = 128;
    localparam int  LOG2N      = 7;
    localparam int  N_BINS     = N_PTS / 2;
    localparam int  RAND_ITEMS = 200;
    localparam int  HOLD_LEN   = 20000;
    localparam int  DRAIN_WAIT = 3000;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef enum logic {EXP_MODEL, EXP_FLAT} t_exp_kind;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        t_exp_kind          kind;
        int                 flat;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           in_valid;
    logic           in_stall;
    wfm_pkg::t_in   in_item;
    logic           out_valid;
    logic           out_stall;
    wfm_pkg::t_out  out_item;

    windowed_fft_magnitude_core #(.FFT_POINTS(N_PTS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    wfm_pkg::t_out bins_due[$];
    logic [15:0] wave_store[N_PTS];
    int     wave_held;
    int     n_errors;
    longint cycle_cnt;
    bit     hold_req;
    longint work_re[N_PTS];
    longint work_im[N_PTS];
    longint atan_tab[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2};

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint rnd_q15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint sat_24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > 32768) return 32768;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic trig(input logic [31:0] phase, output longint c, output longint s);
        logic [1:0]        quad;
        longint unsigned   frac;
        longint            z, x, y, dx, dy;
        quad = phase[31:30];
        frac = longint'(phase[29:0]);
        z = longint'((frac * 64'd1686629713 + (64'd1 << 29)) >> 30);
        x = 652032874;
        y = 0;
        for (int k = 0; k < 30; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_tab[k];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_tab[k];
            end
        end
        x = clamp_one(rnd_q15(x));
        y = clamp_one(rnd_q15(y));
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic longint unsigned isqrt_round(longint unsigned v);
        longint unsigned r, bitv, rem;
        r = 0;
        bitv = 64'd1 << 62;
        rem = v;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= r + bitv) begin
                rem = rem - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        if (v > r * r + r) r++;
        return r;
    endfunction

    task automatic compute_spectrum(input int m);
        longint          c, s, smp, w, x, tr, ti, ar, ai, br, bi;
        longint unsigned den, ure, uim, mag;
        logic [31:0]     ph;
        int              j, half, p, q;
        wfm_pkg::t_out   b;
        for (int i = 0; i < N_PTS; i++) begin
            x = 0;
            if (i < m) begin
                smp = longint'($signed(wave_store[i]));
                w = 32768;
                if (m > 1) begin
                    den = longint'(m - 1);
                    ph = 32'(((longint'(i) << 32) + den / 2) / den);
                    trig(ph, c, s);
                    w = (32768 - c + 1) >>> 1;
                end
                x = rnd_q15(smp * w);
            end
            work_re[i] = sat_24(x);
            work_im[i] = 0;
        end
        for (int i = 0; i < N_PTS; i++) begin
            j = 0;
            for (int k = 0; k < LOG2N; k++) j = (j << 1) | ((i >> k) & 1);
            if (i < j) begin
                tr = work_re[i]; ti = work_im[i];
                work_re[i] = work_re[j]; work_im[i] = work_im[j];
                work_re[j] = tr; work_im[j] = ti;
            end
        end
        for (int span = 2; span <= N_PTS; span = span << 1) begin
            half = span >> 1;
            for (int jj = 0; jj < half; jj++) begin
                ph = 32'((longint'(jj) << 32) / span);
                trig(ph, c, s);
                for (int base = 0; base < N_PTS; base += span) begin
                    p = base + jj;
                    q = p + half;
                    br = work_re[q]; bi = work_im[q];
                    tr = rnd_q15(c * br + s * bi);
                    ti = rnd_q15(c * bi - s * br);
                    ar = work_re[p]; ai = work_im[p];
                    work_re[p] = sat_24(ar + tr);
                    work_im[p] = sat_24(ai + ti);
                    work_re[q] = sat_24(ar - tr);
                    work_im[q] = sat_24(ai - ti);
                end
            end
        end
        for (int k = 0; k < N_BINS; k++) begin
            ure = longint'(work_re[k] < 0 ? -work_re[k] : work_re[k]);
            uim = longint'(work_im[k] < 0 ? -work_im[k] : work_im[k]);
            mag = isqrt_round(ure * ure + uim * uim);
            if (mag > 64'h7FFFFF) mag = 64'h7FFFFF;
            b.bin_index     = 6'(k);
            b.bin_real      = 24'(work_re[k]);
            b.bin_imag      = 24'(work_im[k]);
            b.bin_magnitude = 23'(mag);
            b.last_bin      = (k == N_BINS - 1);
            bins_due.push_back(b);
        end
    endtask

    task automatic take_sample(input wfm_pkg::t_in it);
        int m;
        if (wave_held < N_PTS) begin
            wave_store[wave_held] = it.sample;
            wave_held++;
        end
        if (it.last_sample) begin
            m = wave_held;
            wave_held = 0;
            compute_spectrum(m);
        end
    endtask

    task automatic offer(input wfm_pkg::t_in it);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        take_sample(it);
    endtask

    task automatic idle(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_windowed_fft_magnitude_core NOT OK");
            $finish;
        end
    end

    // check delivered bins, then set the stall pattern for the next cycle
    initial begin
        int             hold_left;
        int             mode;
        int             mode_left;
        wfm_pkg::t_out  e;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall) begin
                if (bins_due.size() == 0) begin
                    $error("unexpected bin %0d", out_item.bin_index);
                    n_errors++;
                end else begin
                    e = bins_due.pop_front();
                    if (out_item.bin_index !== e.bin_index) begin
                        $error("bin_index exp %0d got %0d", e.bin_index, out_item.bin_index);
                        n_errors++;
                    end
                    if (out_item.bin_real !== e.bin_real) begin
                        $error("bin_real exp %0d got %0d", e.bin_real, out_item.bin_real);
                        n_errors++;
                    end
                    if (out_item.bin_imag !== e.bin_imag) begin
                        $error("bin_imag exp %0d got %0d", e.bin_imag, out_item.bin_imag);
                        n_errors++;
                    end
                    if (out_item.bin_magnitude !== e.bin_magnitude) begin
                        $error("bin_magnitude exp %0d got %0d", e.bin_magnitude,
                               out_item.bin_magnitude);
                        n_errors++;
                    end
                    if (out_item.last_bin !== e.last_bin) begin
                        $error("last_bin exp %0d got %0d", e.last_bin, out_item.last_bin);
                        n_errors++;
                    end
                end
            end
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 200);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    initial begin
        t_row           rows[$];
        wfm_pkg::t_in   it;
        wfm_pkg::t_out  fb;
        int     sent;
        int     burst;
        int     len;
        int     frames;
        int     n_due;
        n_errors  = 0;
        cycle_cnt = 0;
        wave_held = 0;
        hold_req  = 1'b0;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;

        rows.push_back('{16'sd0, 1'b1, EXP_FLAT, 0});
        rows.push_back('{16'sh7FFF, 1'b1, EXP_FLAT, 32767});
        rows.push_back('{16'sh8000, 1'b1, EXP_FLAT, -32768});
        rows.push_back('{16'sh8000, 1'b0, EXP_MODEL, 0});
        rows.push_back('{16'sh7FFF, 1'b1, EXP_FLAT, 0});
        rows.push_back('{16'sh7FFF, 1'b0, EXP_MODEL, 0});
        rows.push_back('{16'sh8000, 1'b0, EXP_MODEL, 0});
        rows.push_back('{16'sh7FFF, 1'b1, EXP_MODEL, 0});
        for (int i = 0; i < 8; i++)
            rows.push_back('{(i % 2) ? 16'shAAAA : 16'sh5555, i == 7, EXP_MODEL, 0});
        for (int i = 0; i < 5; i++)
            rows.push_back('{(i % 2) ? 16'sh8000 : 16'sh7FFF, i == 4, EXP_MODEL, 0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            it.sample      = rows[r].sample;
            it.last_sample = rows[r].last;
            n_due = bins_due.size();
            offer(it);
            if (rows[r].kind == EXP_FLAT) begin
                while (bins_due.size() > n_due) void'(bins_due.pop_back());
                for (int k = 0; k < N_BINS; k++) begin
                    fb.bin_index     = 6'(k);
                    fb.bin_real      = 24'(rows[r].flat);
                    fb.bin_imag      = '0;
                    fb.bin_magnitude = 23'(rows[r].flat < 0 ? -rows[r].flat : rows[r].flat);
                    fb.last_bin      = (k == N_BINS - 1);
                    bins_due.push_back(fb);
                end
            end
            if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 5));
        end

        // pause until every bin is back
        idle(1);
        wait (bins_due.size() == 0);
        idle(50);

        sent = 0;
        burst = $urandom_range(1, 20);
        frames = 0;
        while (sent < RAND_ITEMS || frames < 4) begin
            case ($urandom_range(0, 19))
                0, 1:    len = $urandom_range(129, 136);
                2, 3:    len = $urandom_range(65, 128);
                4, 5, 6: len = $urandom_range(17, 64);
                default: len = $urandom_range(1, 16);
            endcase
            if (frames == 2) hold_req <= 1'b1;
            for (int i = 0; i < len; i++) begin
                it.sample      = pick_sample();
                it.last_sample = (i == len - 1) || ($urandom_range(0, 60) == 0);
                offer(it);
                sent++;
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 20);
                    if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
                end
            end
            frames++;
        end

        idle(1);
        while (bins_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0 && bins_due.size() == 0) begin
            $display("tb_windowed_fft_magnitude_core OK");
        end else begin
            $display("tb_windowed_fft_magnitude_core NOT OK");
        end
        $finish;
    end
endmodule

[files.f]
rtl/wfm_pkg.sv
rtl/wfm_front.sv
rtl/wfm_queue.sv
rtl/wfm_cordic.sv
rtl/wfm_engine.sv
rtl/windowed_fft_magnitude_core.sv
bench/tb_windowed_fft_magnitude_core.sv
